// ===== rtl/rbsa_pkg.sv =====
// Shared types and constants for the rounded box shadow alpha block.
// Standalone package; used by every rtl/ module but rbsa_isqrt.
`default_nettype none

package rbsa_pkg;

  // Field and register widths
  localparam int PIX_W     = 8;
  localparam int HALF_W    = 9;   // half-pixel coordinates and offsets
  localparam int Q16_W     = 16;  // radius and falloff coefficient
  localparam int SUMSQ_W   = 20;  // ox^2 + oy^2
  localparam int DIST_SHIFT = 14; // radicand = sum of squares * 16384
  localparam int DIST_W    = 18;  // Q10.8 distance
  localparam int DSQ_W     = 2 * DIST_W;
  localparam int PROD_W    = DSQ_W + Q16_W;
  localparam int EXPO_SHIFT = 28; // d^2 * coef -> Q4.4
  localparam int ALPHA_W   = 8;

  // Parameter defaults
  localparam int SPRITE_MAX_DEF = 256;
  localparam int EXP_DEPTH_DEF  = 256;
  localparam int TAYLOR_TERMS   = 20;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLOFF = 2'd3;

  // Register reset values
  localparam logic [HALF_W-1:0] CENTER_RST  = 9'd52;
  localparam logic [HALF_W-1:0] INNER_RST   = 9'd2;
  localparam logic [Q16_W-1:0]  RADIUS_RST  = 16'd1280;
  localparam logic [Q16_W-1:0]  FALLOFF_RST = 16'd554;

  localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic               in_core;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/rbsa_isqrt.sv =====
// Pipelined integer square root, STEPS root bits per register stage.
// No package dependency; instantiated by rounded_box_shadow_alpha.
`default_nettype none

module rbsa_isqrt #(
  parameter int ROOT_W = 18,
  parameter int STEPS  = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [2*ROOT_W-1:0] in_rad,
  output logic                out_valid,
  output logic [ROOT_W-1:0]   out_root
);

  localparam int STAGES = (ROOT_W + STEPS - 1) / STEPS;
  localparam int RW     = STAGES * STEPS;
  localparam int REM_W  = RW + 3;

  logic [STAGES-1:0] valid_r;
  logic [REM_W-1:0]  rem_r  [STAGES];
  logic [RW-1:0]     root_r [STAGES];
  logic [2*RW-1:0]   rad_r  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic             v_in;
    logic [REM_W-1:0] rem_in;
    logic [RW-1:0]    root_in;
    logic [2*RW-1:0]  rad_in;
    logic [REM_W-1:0] rem_nxt;
    logic [RW-1:0]    root_nxt;
    logic [2*RW-1:0]  rad_nxt;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = (2*RW)'(in_rad);
    end else begin : g_next
      assign v_in    = valid_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign rad_in  = rad_r[s-1];
    end

    // One root bit per step: bring down two radicand bits, try 4*root+1.
    always_comb begin
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      rem_nxt  = rem_in;
      root_nxt = root_in;
      rad_nxt  = rad_in;
      for (int i = 0; i < STEPS; i++) begin
        rem_sh = {rem_nxt[REM_W-3:0], rad_nxt[2*RW-1 -: 2]};
        trial  = REM_W'({root_nxt, 2'b01});
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_nxt[RW-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_nxt[RW-2:0], 1'b0};
        end
        rad_nxt = {rad_nxt[2*RW-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else begin
        valid_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_nxt;
      root_r[s] <= root_nxt;
      rad_r[s]  <= rad_nxt;
    end
  end

  assign out_valid = valid_r[STAGES-1];
  assign out_root  = root_r[STAGES-1][ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/rbsa_exp_rom.sv =====
// Falloff table round(255*exp(-k*16/DEPTH)), built at elaboration, registered read.
// Depends on rbsa_pkg for widths and the series length.
`default_nettype none

module rbsa_exp_rom #(
  parameter int DEPTH = rbsa_pkg::EXP_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic [$clog2(DEPTH)-1:0]            rd_idx,
  output logic [rbsa_pkg::ALPHA_W-1:0]        rd_data
);
  import rbsa_pkg::*;

  localparam longint unsigned ONE    = 64'd1 << 30;
  localparam longint unsigned HALF   = 64'd1 << 29;
  localparam longint unsigned STEP_X = (64'd16 << 30) / DEPTH;

  typedef logic [ALPHA_W-1:0] rom_t [DEPTH];

  // exp(-STEP_X) by a truncated Taylor series in Q2.30, then repeated products.
  function automatic rom_t build_rom();
    rom_t              tbl;
    longint unsigned   term;
    longint unsigned   e;
    longint unsigned   r;
    longint unsigned   a;
    longint            sum;
    term = ONE;
    sum  = longint'(ONE);
    e    = ONE;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = ((term * STEP_X) >> 30) / 64'(n);
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    r = (sum > 0) ? 64'(sum) : 64'd0;
    for (int k = 0; k < DEPTH; k++) begin
      a = (64'd255 * e + HALF) >> 30;
      tbl[k] = (a > 64'd255) ? ALPHA_OPAQUE : a[ALPHA_W-1:0];
      e = (e * r) >> 30;
    end
    return tbl;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [ALPHA_W-1:0] data_r;

  always_ff @(posedge clk) begin
    data_r <= ROM[rd_idx];
  end

  assign rd_data = data_r;

endmodule

`default_nettype wire

// ===== rtl/rounded_box_shadow_alpha.sv =====
// Rounded box shadow alpha: pixel coordinate in, Gaussian shadow coverage out.
// Depends on rbsa_pkg, rbsa_isqrt and rbsa_exp_rom.
//
// Usage:
//   Input beat: drive in_data (pixel_x, pixel_y) and raise start; the beat is
//   taken at a rising edge where start is high and busy is low. busy is high
//   only during reset and in the cycle that follows it, so a new pixel enters every cycle.
//   Result beat: out_valid marks out_data (alpha, in_core) for one cycle. The
//   receiver cannot stall; every accepted pixel yields exactly one result,
//   in order.
//   Throughput is one pixel per clock. The pipeline holds the offset and
//   squaring stages, six square root stages of three root bits each, and the
//   distance, d squared, falloff product, exponent and table read stages.
//   Configuration: cfg_we, cfg_index and cfg_wdata write one register per
//   edge (0 center, 1 inner half size, 2 corner radius, 3 falloff); write
//   only while no pixel is in flight.
//   Reset (synchronous, rst_n low) restores the register defaults and empties
//   the pipeline; the falloff table is a constant and needs no fill.
`default_nettype none

module rounded_box_shadow_alpha #(
  parameter int SPRITE_MAX      = rbsa_pkg::SPRITE_MAX_DEF,
  parameter int EXP_TABLE_DEPTH = rbsa_pkg::EXP_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  rbsa_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  output rbsa_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [rbsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbsa_pkg::Q16_W-1:0]         cfg_wdata
);
  import rbsa_pkg::*;

  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int TIX_W = 8 + $clog2(EXP_TABLE_DEPTH + 1);
  localparam logic [HALF_W-1:0] P_MAX = HALF_W'(SPRITE_MAX - 1);
  localparam int RAD_PAD = 2 * DIST_W - SUMSQ_W - DIST_SHIFT;
  localparam int LATENCY = 13;

  // ---------------- configuration ----------------
  logic [HALF_W-1:0] center_r;
  logic [HALF_W-1:0] inner_r;
  logic [Q16_W-1:0]  radius_r;
  logic [Q16_W-1:0]  falloff_r;
  logic              busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r  <= CENTER_RST;
      inner_r   <= INNER_RST;
      radius_r  <= RADIUS_RST;
      falloff_r <= FALLOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER:  center_r  <= cfg_wdata[HALF_W-1:0];
        CFG_INNER:   inner_r   <= cfg_wdata[HALF_W-1:0];
        CFG_RADIUS:  radius_r  <= cfg_wdata;
        CFG_FALLOFF: falloff_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  logic in_acc;
  assign in_acc = start & ~busy_r;

  // ---------------- stage A: per-axis offsets ----------------
  function automatic logic [HALF_W-1:0] axis_ofs(input logic [PIX_W-1:0] p,
                                                 input logic [HALF_W-1:0] ctr,
                                                 input logic [HALF_W-1:0] inner);
    logic [HALF_W-1:0] pc;
    logic [HALF_W-1:0] pos;
    logic [HALF_W-1:0] a;
    pc  = (HALF_W'(p) > P_MAX) ? P_MAX : HALF_W'(p);
    pos = {pc[HALF_W-2:0], 1'b1};
    a   = (pos >= ctr) ? pos - ctr : ctr - pos;
    return (a > inner) ? a - inner : '0;
  endfunction

  logic              v_a_r;
  logic [HALF_W-1:0] ox_a_r;
  logic [HALF_W-1:0] oy_a_r;

  always_ff @(posedge clk) begin
    ox_a_r <= axis_ofs(in_data.pixel_x, center_r, inner_r);
    oy_a_r <= axis_ofs(in_data.pixel_y, center_r, inner_r);
  end

  // ---------------- stage B: sum of squares ----------------
  logic               v_b_r;
  logic [SUMSQ_W-1:0] sum_sq_r;

  always_ff @(posedge clk) begin
    sum_sq_r <= SUMSQ_W'(18'(ox_a_r) * 18'(ox_a_r)) + SUMSQ_W'(18'(oy_a_r) * 18'(oy_a_r));
  end

  // ---------------- square root pipeline ----------------
  logic              v_q;
  logic [DIST_W-1:0] dist_q;

  rbsa_isqrt #(
    .ROOT_W (DIST_W),
    .STEPS  (3)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_b_r),
    .in_rad    ({{RAD_PAD{1'b0}}, sum_sq_r, {DIST_SHIFT{1'b0}}}),
    .out_valid (v_q),
    .out_root  (dist_q)
  );

  // ---------------- stage D: distance past the corner ----------------
  logic              v_d_r;
  logic              core_d_r;
  logic [DIST_W-1:0] d_d_r;

  always_ff @(posedge clk) begin
    core_d_r <= (dist_q <= DIST_W'(radius_r));
    d_d_r    <= dist_q - DIST_W'(radius_r);
  end

  // ---------------- stage E: d squared ----------------
  logic             v_e_r;
  logic             core_e_r;
  logic [DSQ_W-1:0] dsq_e_r;

  always_ff @(posedge clk) begin
    core_e_r <= core_d_r;
    dsq_e_r  <= DSQ_W'(d_d_r) * DSQ_W'(d_d_r);
  end

  // ---------------- stage F: times falloff ----------------
  logic              v_f_r;
  logic              core_f_r;
  logic [PROD_W-1:0] prod_f_r;

  always_ff @(posedge clk) begin
    core_f_r <= core_e_r;
    prod_f_r <= PROD_W'(dsq_e_r) * PROD_W'(falloff_r);
  end

  // ---------------- stage G: Q4.4 exponent and table index ----------------
  logic              v_g_r;
  logic              core_g_r;
  logic [IDX_W-1:0]  idx_g_r;
  logic [PROD_W:0]   expo_rnd;
  logic [PROD_W-EXPO_SHIFT:0] expo_full;
  logic [7:0]        expo;
  logic [TIX_W-1:0]  tix;

  always_comb begin
    expo_rnd  = (PROD_W+1)'(prod_f_r) + ((PROD_W+1)'(1) << (EXPO_SHIFT - 1));
    expo_full = expo_rnd[PROD_W:EXPO_SHIFT];
    // saturate at 15.9375
    expo      = (expo_full > (PROD_W-EXPO_SHIFT+1)'(255)) ? 8'hFF : expo_full[7:0];
    tix       = TIX_W'(expo) * TIX_W'(EXP_TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    core_g_r <= core_f_r;
    idx_g_r  <= tix[8 +: IDX_W];
  end

  // ---------------- stage H: table read ----------------
  logic               v_h_r;
  logic               core_h_r;
  logic [ALPHA_W-1:0] rom_alpha;

  rbsa_exp_rom #(
    .DEPTH (EXP_TABLE_DEPTH)
  ) u_exp_rom (
    .clk     (clk),
    .rd_idx  (idx_g_r),
    .rd_data (rom_alpha)
  );

  always_ff @(posedge clk) begin
    core_h_r <= core_g_r;
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_d_r <= 1'b0;
      v_e_r <= 1'b0;
      v_f_r <= 1'b0;
      v_g_r <= 1'b0;
      v_h_r <= 1'b0;
    end else begin
      v_a_r <= in_acc;
      v_b_r <= v_a_r;
      v_d_r <= v_q;
      v_e_r <= v_d_r;
      v_f_r <= v_e_r;
      v_g_r <= v_f_r;
      v_h_r <= v_g_r;
    end
  end

  assign out_valid        = v_h_r;
  assign out_data.alpha   = core_h_r ? ALPHA_OPAQUE : rom_alpha;
  assign out_data.in_core = core_h_r;

  // ---------------- assertions ----------------
  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##LATENCY out_valid)
    else $error("accepted pixel produced no result beat");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, LATENCY))
    else $error("result beat without an accepted pixel");

  a_core_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.in_core) |-> (out_data.alpha == ALPHA_OPAQUE))
    else $error("core pixel is not fully opaque");

  a_stage_chain: assert property (@(posedge clk) disable iff (!rst_n)
    v_g_r |=> v_h_r)
    else $error("valid bit lost between exponent and table stages");

endmodule

`default_nettype wire

// ===== test/rounded_box_shadow_alpha_tb.sv =====
// Self-checking testbench for rounded_box_shadow_alpha: pixels go in, shadow beats are
// checked against a predictor kept in step with every register write.
// Depends on rbsa_pkg and the rounded_box_shadow_alpha RTL.
module rounded_box_shadow_alpha_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rbsa_pkg::*;

  localparam int SPRITE_MAX  = SPRITE_MAX_DEF;
  localparam int EXP_DEPTH   = EXP_DEPTH_DEF;
  localparam int STALL_LIMIT = 500;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_data;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [Q16_W-1:0]     cfg_wdata;

  rounded_box_shadow_alpha u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor state: register copies and the falloff table
  logic [HALF_W-1:0]  m_center;
  logic [HALF_W-1:0]  m_inner;
  logic [Q16_W-1:0]   m_radius;
  logic [Q16_W-1:0]   m_falloff;
  logic [ALPHA_W-1:0] falloff_lut [EXP_DEPTH];

  out_item_t pending_alpha [$];
  out_item_t want;

  int errors;
  int items_sent;
  int beats_checked;
  int core_beats;
  int clear_beats;
  int settings_used;
  int idle_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void build_falloff_table();
    longint unsigned one, x, term, r, e, a;
    longint          sum;
    one  = 64'd1 << 30;
    x    = (64'd16 << 30) / EXP_DEPTH;
    term = one;
    sum  = one;
    e    = one;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = ((term * x) >> 30) / n;
      if (n % 2) sum -= term;
      else sum += term;
    end
    r = (sum > 0) ? sum : 0;
    for (int k = 0; k < EXP_DEPTH; k++) begin
      a = (255 * e + (64'd1 << 29)) >> 30;
      falloff_lut[k] = (a > 255) ? ALPHA_OPAQUE : a[ALPHA_W-1:0];
      e = (e * r) >> 30;
    end
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, probe;
    res   = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v   -= res + probe;
        res  = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  // Offset from the core edge along one axis, half-pixel units
  function automatic longint unsigned axis_gap(logic [PIX_W-1:0] p);
    longint unsigned q, pos, a;
    q = p;
    if (q > SPRITE_MAX - 1) q = SPRITE_MAX - 1;
    pos = 2 * q + 1;
    a   = (pos >= m_center) ? pos - m_center : m_center - pos;
    return (a > m_inner) ? a - m_inner : 0;
  endfunction

  function automatic out_item_t predict_shadow(in_item_t px);
    longint unsigned ox, oy, dist_q8, d, t, idx;
    out_item_t       res;
    ox      = axis_gap(px.pixel_x);
    oy      = axis_gap(px.pixel_y);
    dist_q8 = int_sqrt((ox * ox + oy * oy) << DIST_SHIFT);
    if (dist_q8 <= m_radius) begin
      res.alpha   = ALPHA_OPAQUE;
      res.in_core = 1'b1;
      return res;
    end
    d = dist_q8 - m_radius;
    t = (d * d * m_falloff + (64'd1 << (EXPO_SHIFT - 1))) >> EXPO_SHIFT;
    if (t > 255) t = 255;
    idx = (t * EXP_DEPTH) >> 8;
    if (idx >= EXP_DEPTH) idx = EXP_DEPTH - 1;
    res.alpha   = falloff_lut[idx];
    res.in_core = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
    in_item_t px;
    px.pixel_x = x;
    px.pixel_y = y;
    start   <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_alpha.push_back(predict_shadow(px));
    items_sent++;
  endtask

  task automatic pixel_gap(int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drop start and wait until every beat in flight has come back
  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_alpha.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [Q16_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_CENTER:  m_center  = val[HALF_W-1:0];
      CFG_INNER:   m_inner   = val[HALF_W-1:0];
      CFG_RADIUS:  m_radius  = val;
      CFG_FALLOFF: m_falloff = val;
      default: ;
    endcase
  endtask

  task automatic write_settings(logic [Q16_W-1:0] center, logic [Q16_W-1:0] inner,
                                logic [Q16_W-1:0] radius, logic [Q16_W-1:0] falloff);
    drain_pipeline();
    put_reg(CFG_CENTER, center);
    put_reg(CFG_INNER, inner);
    put_reg(CFG_RADIUS, radius);
    put_reg(CFG_FALLOFF, falloff);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic test_default_registers();
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd25, 8'd25);
    send_pixel(8'd26, 8'd26);
    send_pixel(8'd30, 8'd25);
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd128, 8'd128);
  endtask

  task automatic test_register_extremes();
    // zero core and steepest falloff: far pixels saturate the exponent
    write_settings(16'd0, 16'd0, 16'd0, 16'hFFFF);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd3, 8'd0);
    // largest core: every pixel lands inside it
    write_settings(16'd511, 16'd511, 16'hFFFF, 16'd0);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd200, 8'd17);
    // zero falloff just outside a zero radius: exponent rounds to zero
    write_settings(16'd256, 16'd0, 16'd0, 16'd0);
    send_pixel(8'd127, 8'd127);
    send_pixel(8'd128, 8'd128);
    send_pixel(8'd0, 8'd255);
    // over-wide writes keep only the low register bits
    write_settings(16'hFFFF, 16'hFE00, 16'd300, 16'd1);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd90, 8'd170);
  endtask

  task automatic write_random_settings();
    logic [Q16_W-1:0] c, i, r, f;
    c = Q16_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'hFFFF)
                                            : $urandom_range(0, 511));
    i = Q16_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                            : $urandom_range(0, 64));
    r = Q16_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 16'hFFFF)
                                            : $urandom_range(0, 8000));
    case ($urandom_range(0, 2))
      0:       f = Q16_W'($urandom_range(0, 2000));
      1:       f = Q16_W'($urandom_range(0, 200));
      default: f = Q16_W'($urandom_range(0, 16'hFFFF));
    endcase
    write_settings(c, i, r, f);
  endtask

  // Mostly raster runs along a row, with scattered single pixels as noise
  task automatic test_random_scan(int idle_pct, int n_items);
    logic [PIX_W-1:0] x, y;
    int               run_left;
    run_left = 0;
    x = '0;
    y = '0;
    write_random_settings();
    for (int n = 0; n < n_items; n++) begin
      if (n > 0 && n % 45 == 0) write_random_settings();
      if (run_left == 0 && $urandom_range(0, 3) != 0) begin
        x        = PIX_W'($urandom_range(0, 255));
        y        = PIX_W'($urandom_range(0, 255));
        run_left = $urandom_range(4, 24);
      end
      if (run_left == 0) begin
        send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)));
      end else begin
        send_pixel(x, y);
        x++;
        if (x == 0) y++;
        run_left--;
      end
      pixel_gap(idle_pct);
    end
  endtask

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_CENTER;
    cfg_wdata = '0;
    m_center  = CENTER_RST;
    m_inner   = INNER_RST;
    m_radius  = RADIUS_RST;
    m_falloff = FALLOFF_RST;
    build_falloff_table();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_registers();
    test_register_extremes();
    test_random_scan(0, 134);
    test_random_scan(59, 133);
    test_random_scan(28, 133);

    drain_pipeline();
    repeat (20) @(posedge clk);
    if (pending_alpha.size() != 0)
      report_mismatch($sformatf("%0d shadow beats never arrived", pending_alpha.size()));
    $display("Sent %0d pixels under %0d register settings; checked %0d beats",
             items_sent, settings_used, beats_checked);
    $display("%0d beats inside the core, %0d fully clear", core_beats, clear_beats);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_alpha.size() == 0) begin
        report_mismatch($sformatf("unexpected beat alpha=%0d in_core=%0d",
                                  out_data.alpha, out_data.in_core));
      end else begin
        want = pending_alpha.pop_front();
        if (out_data.alpha !== want.alpha)
          report_mismatch($sformatf("beat %0d alpha got %0d, wanted %0d",
                                    beats_checked, out_data.alpha, want.alpha));
        if (out_data.in_core !== want.in_core)
          report_mismatch($sformatf("beat %0d in_core got %0d, wanted %0d",
                                    beats_checked, out_data.in_core, want.in_core));
        if (want.in_core) core_beats++;
        if (want.alpha == '0) clear_beats++;
        beats_checked++;
      end
    end
  end

  // Watchdog: count edges with no beat moving in either direction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1 || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no activity for %0d cycles", idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
rtl/rbsa_pkg.sv
rtl/rbsa_isqrt.sv
rtl/rbsa_exp_rom.sv
rtl/rounded_box_shadow_alpha.sv
test/rounded_box_shadow_alpha_tb.sv
